// ===== hw/rtl/scc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types, constants and calendar helper functions for the seconds/calendar
// converter.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int unsigned YOFF_W = 7;   // year offset from 2000, 0..99

  localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
  localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
  localparam logic [31:0] SECS_PER_MIN  = 32'd60;
  localparam logic [11:0] FIRST_YEAR    = 12'd2000;
  localparam logic [11:0] LAST_YEAR     = 12'd2099;
  localparam logic [YOFF_W-1:0] LAST_YOFF = YOFF_W'(99);
  localparam logic [15:0] LAST_DAY_INDEX = 16'd364;
  localparam logic [31:0] HOURS_PER_DAY = 32'd24;
  localparam logic [31:0] MINS_PER_HOUR = 32'd60;

  // reciprocals for the constant divisions
  localparam logic [31:0] DAY_RECIP  = 32'd50903317;  // ceil(2^35 / 675), on ts >> 7
  localparam logic [31:0] HOUR_RECIP = 32'd149131;    // ceil(2^29 / 3600), x < 2^17
  localparam logic [31:0] MIN_RECIP  = 32'd4370;      // ceil(2^18 / 60), x < 2^12

  // ALU operation codes
  localparam logic [1:0] ALU_ADD  = 2'd0;
  localparam logic [1:0] ALU_SUB  = 2'd1;
  localparam logic [1:0] ALU_MAC  = 2'd2;
  localparam logic [1:0] ALU_MSUB = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] k;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] res;
    logic [31:0] hi;
    logic        borrow;
  } alu_rsp_t;

  typedef struct packed {
    logic        func;
    logic [31:0] in_timestamp;
    logic [7:0]  in_speed;
    logic [11:0] in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic [4:0]  in_hour;
    logic [5:0]  in_minute;
    logic [5:0]  in_second;
  } in_t;

  typedef struct packed {
    logic [31:0] out_timestamp;
    logic [11:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [5:0]  out_second;
    logic [7:0]  out_speed;
  } out_t;

  function automatic logic [8:0] year_len(input logic is_leap);
    return is_leap ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic is_leap);
    logic [4:0] len;
    unique case (month)
      4'd2:                      len = is_leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== hw/rtl/scc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_in_if / scc_out_if
// Valid/ready channels carrying converter requests and results.
// ----------------------------------------------------------------------------
interface scc_in_if;
  import scc_pkg::*;

  logic valid;
  logic ready;
  in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface scc_out_if;
  import scc_pkg::*;

  logic valid;
  logic ready;
  out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/seconds_calendar_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seconds_calendar_converter
// Converts between seconds since 2000-01-01 00:00:00 and calendar fields.
// ----------------------------------------------------------------------------
// One transaction at a time. With func 0 the timestamp is split into days,
// hours, minutes and seconds by three reciprocal multiplications, each
// followed by a multiply-subtract for the remainder, all through the shared
// ALU; then whole years are stripped one per cycle and whole months one per
// cycle. With func 1 years and months are summed one per cycle and the day
// and time are folded in with five more ALU steps. A finished result sits
// in an output register, so the next request is taken while the result
// waits to be read.
module seconds_calendar_converter (
  input  logic       clk,
  input  logic       rst,
  scc_in_if.sink     item,
  scc_out_if.source  result
);
  import scc_pkg::*;

  scc_out_if core_res ();

  logic out_valid;
  out_t out_data;

  scc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (core_res)
  );

  assign core_res.ready = !out_valid || result.ready;
  assign result.valid   = out_valid;
  assign result.data    = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (core_res.ready) begin
      out_valid <= core_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (core_res.valid && core_res.ready) begin
      out_data <= core_res.data;
    end
  end

endmodule

// ===== hw/rtl/scc_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_alu
// Shared 32-bit add / subtract-compare / multiply-accumulate /
// multiply-subtract unit; the upper product word is also returned.
// ----------------------------------------------------------------------------
module scc_alu (
  input  scc_pkg::alu_req_t req,
  output scc_pkg::alu_rsp_t rsp
);
  import scc_pkg::*;

  logic [32:0] diff;
  logic [63:0] prod;

  assign diff = {1'b0, req.a} - {1'b0, req.b};
  assign prod = {32'b0, req.a} * {32'b0, req.k};

  always_comb begin
    rsp.borrow = 1'b0;
    rsp.hi     = prod[63:32];
    unique case (req.op)
      ALU_ADD: rsp.res = req.a + req.b;
      ALU_SUB: begin
        rsp.res    = diff[31:0];
        rsp.borrow = diff[32];
      end
      ALU_MAC:  rsp.res = prod[31:0] + req.b;
      ALU_MSUB: rsp.res = req.b - prod[31:0];
      default:  rsp.res = '0;
    endcase
  end

endmodule

// ===== hw/rtl/scc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_core
// Sequencer for both conversion directions; the day and seconds sums go
// through the one shared ALU, the year and month counters step outside it.
// ----------------------------------------------------------------------------
module scc_core (
  input  logic       clk,
  input  logic       rst,
  scc_in_if.sink     item,
  scc_out_if.source  result
);
  import scc_pkg::*;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DIV_DAY  = 5'd1;
  localparam logic [4:0] S_REM_DAY  = 5'd2;
  localparam logic [4:0] S_DIV_HOUR = 5'd3;
  localparam logic [4:0] S_REM_HOUR = 5'd4;
  localparam logic [4:0] S_DIV_MIN  = 5'd5;
  localparam logic [4:0] S_REM_MIN  = 5'd6;
  localparam logic [4:0] S_YEAR     = 5'd7;
  localparam logic [4:0] S_MONTH    = 5'd8;
  localparam logic [4:0] S_YSUM     = 5'd9;
  localparam logic [4:0] S_MSUM     = 5'd10;
  localparam logic [4:0] S_DADD     = 5'd11;
  localparam logic [4:0] S_DDEC     = 5'd12;
  localparam logic [4:0] S_MUL_H    = 5'd13;
  localparam logic [4:0] S_MUL_M    = 5'd14;
  localparam logic [4:0] S_MUL_S    = 5'd15;
  localparam logic [4:0] S_DONE     = 5'd16;

  logic [4:0]        st, st_next;
  logic [31:0]       num, num_next;     // timestamp/remainder, or running sum
  logic [15:0]       days, days_next;
  logic [YOFF_W-1:0] yoff, yoff_next;
  logic [YOFF_W-1:0] ytgt, ytgt_next;
  logic [3:0]        month, month_next;
  logic [3:0]        mtgt, mtgt_next;
  logic [4:0]        hour, hour_next;
  logic [5:0]        minute, minute_next;
  logic [5:0]        second, second_next;
  in_t               inp, inp_next;

  alu_req_t    req;
  alu_rsp_t    rsp;

  scc_alu u_alu (
    .req (req),
    .rsp (rsp)
  );

  assign item.ready   = (st == S_IDLE);
  assign result.valid = (st == S_DONE);

  always_comb begin
    result.data.out_speed = inp.in_speed;
    if (inp.func) begin
      result.data.out_timestamp = num;
      result.data.out_year      = inp.in_year;
      result.data.out_month     = inp.in_month;
      result.data.out_day       = inp.in_day;
      result.data.out_hour      = inp.in_hour;
      result.data.out_minute    = inp.in_minute;
      result.data.out_second    = inp.in_second;
    end else begin
      result.data.out_timestamp = '0;
      result.data.out_year      = FIRST_YEAR + 12'(yoff);
      result.data.out_month     = month;
      result.data.out_day       = days[4:0] + 5'd1;
      result.data.out_hour      = hour;
      result.data.out_minute    = minute;
      result.data.out_second    = second;
    end
  end

  always_comb begin
    st_next     = st;
    num_next    = num;
    days_next   = days;
    yoff_next   = yoff;
    ytgt_next   = ytgt;
    month_next  = month;
    mtgt_next   = mtgt;
    hour_next   = hour;
    minute_next = minute;
    second_next = second;
    inp_next    = inp;
    req         = '{op: ALU_ADD, a: '0, b: '0, k: '0};

    unique case (st)
      S_IDLE: begin
        if (item.valid) begin
          inp_next   = item.data;
          yoff_next  = '0;
          month_next = 4'd1;
          if (!item.data.func) begin
            num_next = item.data.in_timestamp;
            st_next  = S_DIV_DAY;
          end else begin
            num_next = '0;
            if (item.data.in_year < FIRST_YEAR) begin
              ytgt_next = '0;
            end else if (item.data.in_year > LAST_YEAR) begin
              ytgt_next = LAST_YOFF;
            end else begin
              ytgt_next = YOFF_W'(item.data.in_year - FIRST_YEAR);
            end
            if (item.data.in_month == 4'd0) begin
              mtgt_next = 4'd1;
            end else if (item.data.in_month > 4'd12) begin
              mtgt_next = 4'd12;
            end else begin
              mtgt_next = item.data.in_month;
            end
            st_next = S_YSUM;
          end
        end
      end

      S_DIV_DAY: begin
        // 86400 = 128 * 675: product >> 35 is the day count
        req.op    = ALU_MAC;
        req.a     = {7'b0, num[31:7]};
        req.k     = DAY_RECIP;
        days_next = rsp.hi[18:3];
        st_next   = S_REM_DAY;
      end

      S_REM_DAY: begin
        req.op   = ALU_MSUB;
        req.a    = {16'b0, days};
        req.k    = SECS_PER_DAY;
        req.b    = num;
        num_next = rsp.res;
        st_next  = S_DIV_HOUR;
      end

      S_DIV_HOUR: begin
        // product >> 29
        req.op    = ALU_MAC;
        req.a     = num;
        req.k     = HOUR_RECIP;
        hour_next = {rsp.hi[1:0], rsp.res[31:29]};
        st_next   = S_REM_HOUR;
      end

      S_REM_HOUR: begin
        req.op   = ALU_MSUB;
        req.a    = {27'b0, hour};
        req.k    = SECS_PER_HOUR;
        req.b    = num;
        num_next = rsp.res;
        st_next  = S_DIV_MIN;
      end

      S_DIV_MIN: begin
        // product >> 18
        req.op      = ALU_MAC;
        req.a       = num;
        req.k       = MIN_RECIP;
        minute_next = rsp.res[23:18];
        st_next     = S_REM_MIN;
      end

      S_REM_MIN: begin
        req.op      = ALU_MSUB;
        req.a       = {26'b0, minute};
        req.k       = SECS_PER_MIN;
        req.b       = num;
        second_next = rsp.res[5:0];
        st_next     = S_YEAR;
      end

      S_YEAR: begin
        req.op = ALU_SUB;
        req.a  = {16'b0, days};
        req.b  = {23'b0, year_len(yoff[1:0] == 2'b00)};
        if (rsp.borrow) begin
          st_next = S_MONTH;
        end else if (yoff == LAST_YOFF) begin
          // past the last year: pin the date to its last day
          days_next = LAST_DAY_INDEX;
          st_next   = S_MONTH;
        end else begin
          days_next = rsp.res[15:0];
          yoff_next = yoff + YOFF_W'(1);
        end
      end

      S_MONTH: begin
        req.op = ALU_SUB;
        req.a  = {16'b0, days};
        req.b  = {27'b0, month_len(month, yoff[1:0] == 2'b00)};
        if (month == 4'd12 || rsp.borrow) begin
          st_next = S_DONE;
        end else begin
          days_next  = rsp.res[15:0];
          month_next = month + 4'd1;
        end
      end

      S_YSUM: begin
        req.op = ALU_ADD;
        req.a  = num;
        req.b  = {23'b0, year_len(yoff[1:0] == 2'b00)};
        if (yoff == ytgt) begin
          st_next = S_MSUM;
        end else begin
          num_next  = rsp.res;
          yoff_next = yoff + YOFF_W'(1);
        end
      end

      S_MSUM: begin
        req.op = ALU_ADD;
        req.a  = num;
        req.b  = {27'b0, month_len(month, ytgt[1:0] == 2'b00)};
        if (month == mtgt) begin
          st_next = S_DADD;
        end else begin
          num_next   = rsp.res;
          month_next = month + 4'd1;
        end
      end

      S_DADD: begin
        req.op   = ALU_ADD;
        req.a    = num;
        req.b    = {27'b0, inp.in_day};
        num_next = rsp.res;
        st_next  = S_DDEC;
      end

      S_DDEC: begin
        // days are one-based; day zero wraps
        req.op   = ALU_SUB;
        req.a    = num;
        req.b    = 32'd1;
        num_next = rsp.res;
        st_next  = S_MUL_H;
      end

      S_MUL_H: begin
        req.op   = ALU_MAC;
        req.a    = num;
        req.k    = HOURS_PER_DAY;
        req.b    = {27'b0, inp.in_hour};
        num_next = rsp.res;
        st_next  = S_MUL_M;
      end

      S_MUL_M: begin
        req.op   = ALU_MAC;
        req.a    = num;
        req.k    = MINS_PER_HOUR;
        req.b    = {26'b0, inp.in_minute};
        num_next = rsp.res;
        st_next  = S_MUL_S;
      end

      S_MUL_S: begin
        req.op   = ALU_MAC;
        req.a    = num;
        req.k    = MINS_PER_HOUR;
        req.b    = {26'b0, inp.in_second};
        num_next = rsp.res;
        st_next  = S_DONE;
      end

      S_DONE: begin
        if (result.ready) begin
          st_next = S_IDLE;
        end
      end

      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    num    <= num_next;
    days   <= days_next;
    yoff   <= yoff_next;
    ytgt   <= ytgt_next;
    month  <= month_next;
    mtgt   <= mtgt_next;
    hour   <= hour_next;
    minute <= minute_next;
    second <= second_next;
    inp    <= inp_next;
  end

endmodule

// ===== hw/rtl/scc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
module scc_port_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_ready,
  input logic               result_valid,
  input logic               result_ready,
  input scc_pkg::out_t      result_data
);

  // result held until taken
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(result_data))
    else $error("result payload changed while stalled");

  // a request keeps the block busy while it converts
  assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready ##1 !item_ready)
    else $error("request accepted while converting");

  // a new result only follows a busy cycle
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(!item_ready))
    else $error("result appeared without a conversion");

endmodule

bind seconds_calendar_converter scc_port_checker u_scc_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_data  (result.data)
);

// ===== sim/scc_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_tb_pkg
// Direction codes and calendar helpers shared by the converter testbench
// and its checker.
// ----------------------------------------------------------------------------
package scc_tb_pkg;

  localparam logic FUNC_SPLIT = 1'b0;   // timestamp -> calendar fields
  localparam logic FUNC_JOIN  = 1'b1;   // calendar fields -> timestamp

  function automatic bit leap_year(input int unsigned year);
    return (year & 3) == 0;
  endfunction

  // month is clamped into 1..12
  function automatic int unsigned month_days(input int unsigned year,
                                             input int unsigned month);
    int unsigned mon;
    mon = (month < 1) ? 1 : ((month > 12) ? 12 : month);
    case (mon)
      2: begin
        return leap_year(year) ? 29 : 28;
      end
      4, 6, 9, 11: begin
        return 30;
      end
      default: begin
        return 31;
      end
    endcase
  endfunction

endpackage

// ===== sim/scc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_checker
// Watches both converter channels, predicts each result from the accepted
// request and compares it field by field with what the block delivers.
// ----------------------------------------------------------------------------
module scc_checker
  import scc_pkg::*;
  import scc_tb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  output int   mismatch_count,
  output int   outstanding
);

  out_t expected_results[$];

  function automatic out_t convert_item(input in_t req);
    out_t        rsp;
    int unsigned days;
    int unsigned secs_left;
    int unsigned year;
    int unsigned month;
    int unsigned ylen;
    int unsigned k;
    bit          done;
    rsp = '0;
    rsp.out_speed = req.in_speed;
    if (req.func == FUNC_SPLIT) begin
      days = req.in_timestamp / SECS_PER_DAY;
      secs_left = req.in_timestamp % SECS_PER_DAY;
      year = FIRST_YEAR;
      month = 1;
      done = 1'b0;
      while (!done) begin
        ylen = leap_year(year) ? 366 : 365;
        if (days < ylen) begin
          done = 1'b1;
        end else begin
          days -= ylen;
          year++;
          // past the last year: pin the date to Dec 31, keep time of day
          if (year > LAST_YEAR) begin
            year = LAST_YEAR;
            days = LAST_DAY_INDEX;
            done = 1'b1;
          end
        end
      end
      while (month < 12 && days >= month_days(year, month)) begin
        days -= month_days(year, month);
        month++;
      end
      rsp.out_timestamp = '0;
      rsp.out_year   = 12'(year);
      rsp.out_month  = 4'(month);
      rsp.out_day    = 5'(days + 1);
      rsp.out_hour   = 5'(secs_left / SECS_PER_HOUR);
      secs_left      = secs_left % SECS_PER_HOUR;
      rsp.out_minute = 6'(secs_left / 60);
      rsp.out_second = 6'(secs_left % 60);
    end else begin
      year = req.in_year;
      month = req.in_month;
      if (year < FIRST_YEAR) year = FIRST_YEAR;
      if (year > LAST_YEAR) year = LAST_YEAR;
      if (month < 1) month = 1;
      if (month > 12) month = 12;
      days = 0;
      for (k = FIRST_YEAR; k < year; k++) days += leap_year(k) ? 366 : 365;
      for (k = 1; k < month; k++) days += month_days(year, k);
      // day zero wraps below the month start; everything is mod 2^32
      days = days + req.in_day - 1;
      rsp.out_timestamp = ((days * 24 + req.in_hour) * 60 + req.in_minute) * 60
                          + req.in_second;
      rsp.out_year   = req.in_year;
      rsp.out_month  = req.in_month;
      rsp.out_day    = req.in_day;
      rsp.out_hour   = req.in_hour;
      rsp.out_minute = req.in_minute;
      rsp.out_second = req.in_second;
    end
    return rsp;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  initial begin
    mismatch_count = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst) begin
      // retire the result first so a same-edge request cannot be matched
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %p", $time, out_data);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("out_timestamp", want.out_timestamp, out_data.out_timestamp);
          check_field("out_year",      want.out_year,      out_data.out_year);
          check_field("out_month",     want.out_month,     out_data.out_month);
          check_field("out_day",       want.out_day,       out_data.out_day);
          check_field("out_hour",      want.out_hour,      out_data.out_hour);
          check_field("out_minute",    want.out_minute,    out_data.out_minute);
          check_field("out_second",    want.out_second,    out_data.out_second);
          check_field("out_speed",     want.out_speed,     out_data.out_speed);
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(convert_item(in_data));
      end
      outstanding <= expected_results.size();
    end
  end

endmodule

// ===== sim/tb_seconds_calendar_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_seconds_calendar_converter
// Drives directed corner cases and random conversions in both directions
// through the converter under changing sender gaps and receiver stalls;
// the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_seconds_calendar_converter;
  import scc_pkg::*;
  import scc_tb_pkg::*;

  localparam int ITEMS_PER_PHASE = 320;
  localparam int NUM_PHASES      = 4;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int DRAIN_CYCLES    = 200;   // longer than the worst conversion

  localparam int PHASE_IDLE [NUM_PHASES] = '{0, 85, 0, 16};
  localparam int PHASE_STALL[NUM_PHASES] = '{0, 0, 85, 16};

  logic clk;
  logic rst;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   cycle_count = 0;
  int   mismatch_count;
  int   outstanding;

  scc_in_if  item();
  scc_out_if result();

  seconds_calendar_converter i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result)
  );

  scc_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (item.valid),
    .in_ready       (item.ready),
    .in_data        (item.data),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .out_data       (result.data),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    result.ready <= ($urandom_range(99, 0) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic in_t stamp_request(input logic [31:0] stamp);
    in_t req;
    req = in_t'({$urandom, $urandom, $urandom});
    req.func = FUNC_SPLIT;
    req.in_timestamp = stamp;
    return req;
  endfunction

  function automatic in_t date_request(input int unsigned y, input int unsigned mo,
                                       input int unsigned d, input int unsigned h,
                                       input int unsigned mi, input int unsigned s);
    in_t req;
    req = in_t'({$urandom, $urandom, $urandom});
    req.func = FUNC_JOIN;
    req.in_year = 12'(y);
    req.in_month = 4'(mo);
    req.in_day = 5'(d);
    req.in_hour = 5'(h);
    req.in_minute = 6'(mi);
    req.in_second = 6'(s);
    return req;
  endfunction

  function automatic in_t random_request();
    in_t         req;
    int unsigned pick;
    int unsigned yo;
    int unsigned mo;
    int unsigned dcount;
    int unsigned secs;
    int unsigned k;
    req = in_t'({$urandom, $urandom, $urandom});
    pick = $urandom_range(99, 0);
    if (req.func == FUNC_SPLIT) begin
      if (pick < 55) begin
        req.in_timestamp = $urandom_range(32'd3155759999, 0);
      end else if (pick < 80) begin
        // land within a couple of seconds of a month start or month end
        yo = $urandom_range(99, 0);
        mo = $urandom_range(12, 1);
        dcount = 365 * yo + (yo + 3) / 4;
        for (k = 1; k < mo; k++) dcount += month_days(2000 + yo, k);
        secs = 0;
        if ($urandom_range(1, 0) == 1) begin
          dcount += month_days(2000 + yo, mo) - 1;
          secs = 86399;
        end
        req.in_timestamp = dcount * 86400 + secs + $urandom_range(4, 0) - 2;
      end
    end else if (pick < 85) begin
      req.in_year = 12'(2000 + $urandom_range(99, 0));
      req.in_month = 4'($urandom_range(12, 1));
      req.in_day = 5'($urandom_range(month_days(req.in_year, req.in_month), 1));
      req.in_hour = 5'($urandom_range(23, 0));
      req.in_minute = 6'($urandom_range(59, 0));
      req.in_second = 6'($urandom_range(59, 0));
    end
    return req;
  endfunction

  task automatic send_item(input in_t req);
    item.valid <= 1'b1;
    item.data <= req;
    do @(posedge clk); while (item.ready !== 1'b1);
    if ($urandom_range(99, 0) < idle_pct) begin
      item.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < idle_pct);
    end
  endtask

  initial begin
    in_t req;
    rst <= 1'b1;
    item.valid <= 1'b0;
    item.data <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // timestamp to fields: epoch, day and year edges, leap day, clamp past 2099
    send_item(stamp_request(32'd0));
    send_item(stamp_request(32'd86399));
    send_item(stamp_request(32'd5183999));
    send_item(stamp_request(32'd5184000));
    send_item(stamp_request(32'd31622399));
    send_item(stamp_request(32'd31622400));
    send_item(stamp_request(32'd3155759999));
    send_item(stamp_request(32'd3155760000));
    req = stamp_request(32'hFFFF_FFFF);
    req.in_speed = 8'hFF;
    send_item(req);

    // fields to timestamp: range ends, saturated year/month, day zero, overflow
    req = date_request(2000, 1, 1, 0, 0, 0);
    req.in_speed = 8'h00;
    send_item(req);
    send_item(date_request(2099, 12, 31, 23, 59, 59));
    send_item(date_request(2000, 2, 29, 12, 30, 30));
    send_item(date_request(2003, 2, 28, 1, 2, 3));
    send_item(date_request(0, 6, 15, 8, 0, 0));
    send_item(date_request(4095, 6, 15, 8, 0, 0));
    send_item(date_request(2024, 0, 10, 0, 0, 0));
    send_item(date_request(2024, 15, 10, 0, 0, 0));
    send_item(date_request(2024, 13, 31, 23, 59, 59));
    send_item(date_request(2000, 1, 0, 0, 0, 0));
    send_item(date_request(2001, 4, 31, 0, 0, 0));
    send_item(date_request(2050, 7, 31, 31, 63, 63));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      idle_pct <= PHASE_IDLE[ph];
      stall_pct <= PHASE_STALL[ph];
      repeat (ITEMS_PER_PHASE) send_item(random_request());
    end
    item.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/scc_pkg.sv
hw/rtl/scc_if.sv
hw/rtl/scc_alu.sv
hw/rtl/scc_core.sv
hw/rtl/seconds_calendar_converter.sv
hw/rtl/scc_checker.sv
sim/scc_tb_pkg.sv
sim/scc_checker.sv
sim/tb_seconds_calendar_converter.sv
